FILE: design/htfc_pkg.sv
// shared types, constants and the crc-8 byte step for the sensor word converter
// no dependencies; used by the top level and htfc_crc_chk by scoped names
`timescale 1ns / 1ps
`default_nettype none

package htfc_pkg;

  // register map of the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegTempGain   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTempOffset = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHumGain    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegHumOffset  = 2'd3;

  localparam logic signed [CfgDataW-1:0] GainReset   = 16'sd4096;
  localparam logic signed [CfgDataW-1:0] OffsetReset = 16'sd0;

  // crc-8, msb first, start value 0, no final xor
  localparam logic [7:0] CrcPoly = 8'h31;

  // pipeline depth, input register to output register
  localparam int unsigned NumStages = 6;

  // temperature: z = floor((17572*s + 176640) / 256), q8 = floor(z / 100) - 12000
  localparam logic [30:0] TempMul  = 31'd17572;
  localparam logic [30:0] TempBias = 31'd176640;
  // floor(z / 100) as (z * ceil(2^30 / 100)) >> 30, exact for z below 2^23
  localparam logic [46:0] RecipHundred = 47'd10737419;
  localparam logic signed [16:0] TempQ8Bias = 17'sd12000;

  // humidity: h = floor((125*s + 128) / 256), q8 = clip(h - 1536, 0, 25600)
  localparam logic [22:0] HumMul   = 23'd125;
  localparam logic [22:0] HumRound = 23'd128;
  localparam logic [14:0] HumBias  = 15'd1536;
  localparam logic [14:0] HumTop   = 15'd27136;
  localparam logic [14:0] HumMax   = 15'd25600;

  localparam logic signed [32:0] GainRound = 33'sd2048;

  typedef logic signed [CfgDataW-1:0] cfg_word_t;
  typedef logic signed [16:0] q8_t;
  typedef logic signed [23:0] value_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/humidity_temp_frame_convert.sv
// top level: crc check, q8 scaling and per-channel calibration of sensor words
// depends on htfc_pkg and htfc_crc_chk
//
//   channel   direction  handshake               word
//   in        sink       in_valid_i / in_stall_o  req_type, data_high, data_low, check_byte
//   out       source     out_valid_o / out_stall_i  value (q8, signed 24), status
//   cfg       sink       cfg_we_i                 cfg_idx_i, cfg_data_i
//
// six register stages, stage 0 to stage 5, the last being the output register
// one word per cycle sustained while out is not stalled; the stage 2 reciprocal multiply
// and stage 4 gain multiply set the depth
// a stall only blocks stages that hold a word, so bubbles close up under a stalled output
// rst_ni clears the stage valid bits and loads gains of 1.0 and offsets of zero
`timescale 1ns / 1ps
`default_nettype none

module humidity_temp_frame_convert (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input words
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              req_type_i,
  input  wire logic [7:0]                        data_high_i,
  input  wire logic [7:0]                        data_low_i,
  input  wire logic [7:0]                        check_byte_i,
  // result words
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [23:0]                     value_o,
  output logic                                   status_o,
  // configuration writes
  input  wire logic                              cfg_we_i,
  input  wire logic [htfc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [htfc_pkg::CfgDataW-1:0]     cfg_data_i
);

  // ---------------------------------------------------------------------------
  // calibration registers
  // ---------------------------------------------------------------------------
  htfc_pkg::cfg_word_t temp_gain_q, temp_offset_q, hum_gain_q, hum_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_gain_q   <= htfc_pkg::GainReset;
      temp_offset_q <= htfc_pkg::OffsetReset;
      hum_gain_q    <= htfc_pkg::GainReset;
      hum_offset_q  <= htfc_pkg::OffsetReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        htfc_pkg::RegTempGain:   temp_gain_q   <= cfg_data_i;
        htfc_pkg::RegTempOffset: temp_offset_q <= cfg_data_i;
        htfc_pkg::RegHumGain:    hum_gain_q    <= cfg_data_i;
        htfc_pkg::RegHumOffset:  hum_offset_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control: a stage loads when it is empty or the next one moves
  // ---------------------------------------------------------------------------
  logic [htfc_pkg::NumStages-1:0] v_q, v_d, en;

  always_comb begin
    en[htfc_pkg::NumStages-1] = !v_q[htfc_pkg::NumStages-1] || !out_stall_i;
    for (int k = htfc_pkg::NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < htfc_pkg::NumStages; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o = !en[0];

  // ---------------------------------------------------------------------------
  // stage 0: crc check, raw word capture
  // ---------------------------------------------------------------------------
  logic        crc_bad;
  logic        sel0_q, err0_q;
  logic [15:0] s0_q;

  htfc_crc_chk u_crc (
    .data_high_i  (data_high_i),
    .data_low_i   (data_low_i),
    .check_byte_i (check_byte_i),
    .mismatch_o   (crc_bad)
  );

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sel0_q <= req_type_i;
      err0_q <= crc_bad;
      s0_q   <= {data_high_i, data_low_i};
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: constant multiplies for both scales
  // ---------------------------------------------------------------------------
  logic        sel1_q, err1_q;
  logic [30:0] tw1_d, tw1_q;
  logic [22:0] hum_raw;
  logic [14:0] hs1_d, hs1_q;

  always_comb begin
    // temperature offset folded in so the quotient stays non-negative
    tw1_d   = {15'd0, s0_q} * htfc_pkg::TempMul + htfc_pkg::TempBias;
    hum_raw = {7'd0, s0_q} * htfc_pkg::HumMul + htfc_pkg::HumRound;
    hs1_d   = hum_raw[22:8];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sel1_q <= sel0_q;
      err1_q <= err0_q;
      tw1_q  <= tw1_d;
      hs1_q  <= hs1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: divide by 100 through the reciprocal, humidity clip
  // ---------------------------------------------------------------------------
  logic        sel2_q, err2_q;
  logic [46:0] recip_prod;
  logic [15:0] tq2_d, tq2_q;
  logic [14:0] hq2_d, hq2_q;

  always_comb begin
    recip_prod = {24'd0, tw1_q[30:8]} * htfc_pkg::RecipHundred;
    tq2_d      = recip_prod[45:30];
    if (hs1_q < htfc_pkg::HumBias) begin
      hq2_d = '0;
    end else if (hs1_q > htfc_pkg::HumTop) begin
      hq2_d = htfc_pkg::HumMax;
    end else begin
      hq2_d = hs1_q - htfc_pkg::HumBias;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sel2_q <= sel1_q;
      err2_q <= err1_q;
      tq2_q  <= tq2_d;
      hq2_q  <= hq2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: q8 reading of the selected channel
  // ---------------------------------------------------------------------------
  logic           sel3_q, err3_q;
  htfc_pkg::q8_t  q8_3_d, q8_3_q;

  always_comb begin
    if (sel2_q) begin
      q8_3_d = $signed({2'b00, hq2_q});
    end else begin
      q8_3_d = $signed({1'b0, tq2_q}) - htfc_pkg::TempQ8Bias;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sel3_q <= sel2_q;
      err3_q <= err2_q;
      q8_3_q <= q8_3_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: gain multiply
  // ---------------------------------------------------------------------------
  logic                sel4_q, err4_q;
  htfc_pkg::cfg_word_t gain;
  logic signed [32:0]  prod4_d, prod4_q;

  always_comb begin
    gain    = sel3_q ? hum_gain_q : temp_gain_q;
    prod4_d = $signed({{16{q8_3_q[16]}}, q8_3_q}) * $signed({{17{gain[15]}}, gain});
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      sel4_q  <= sel3_q;
      err4_q  <= err3_q;
      prod4_q <= prod4_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: round off 12 gain fraction bits, subtract offset, output register
  // the q8 range times any 16-bit gain stays far inside 24 bits, so no clamp fires
  // ---------------------------------------------------------------------------
  htfc_pkg::cfg_word_t offset;
  logic signed [32:0]  rounded;
  htfc_pkg::value_t    value5_d, value5_q;
  logic                err5_q;

  always_comb begin
    offset  = sel4_q ? hum_offset_q : temp_offset_q;
    rounded = prod4_q + htfc_pkg::GainRound;
    if (err4_q) begin
      value5_d = '0;
    end else begin
      value5_d = $signed({{3{rounded[32]}}, rounded[32:12]})
               - $signed({{8{offset[15]}}, offset});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      err5_q   <= err4_q;
      value5_q <= value5_d;
    end
  end

  assign out_valid_o = v_q[htfc_pkg::NumStages-1];
  assign value_o     = value5_q;
  assign status_o    = err5_q;

endmodule

`default_nettype wire

FILE: design/htfc_crc_chk.sv
// crc-8 check of a two-byte sensor word against its received check byte
// depends on htfc_pkg for the crc byte step
`timescale 1ns / 1ps
`default_nettype none

module htfc_crc_chk (
  input  wire logic [7:0] data_high_i,
  input  wire logic [7:0] data_low_i,
  input  wire logic [7:0] check_byte_i,
  output logic            mismatch_o
);

  logic [7:0] crc_hi;
  logic [7:0] crc_full;

  // high byte first, then low byte
  assign crc_hi     = htfc_pkg::crc8_byte(8'h00, data_high_i);
  assign crc_full   = htfc_pkg::crc8_byte(crc_hi, data_low_i);
  assign mismatch_o = (crc_full != check_byte_i);

endmodule

`default_nettype wire

FILE: design/htfc_checker.sv
// port-level checks of the sensor word converter, bound to the top level
// depends on humidity_temp_frame_convert being compiled first
`timescale 1ns / 1ps
`default_nettype none

module htfc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [23:0] value_o,
  input wire logic               status_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(status_o))
    else $error("stalled result word changed");

  // a crc failure always carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> value_o == 24'sd0)
    else $error("crc failure with nonzero value");

  // input backs up only when the pipe is full behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // with the output free, the input is not stalled in the next cycle unless out is stalled then
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i && in_valid_i |=> !in_stall_o || $past(out_stall_i) || out_stall_i)
    else $error("input stalled with free output");

endmodule

bind humidity_temp_frame_convert htfc_checker u_htfc_checker (.*);

`default_nettype wire
